[src/ahpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ahpt_pkg;

   localparam int AVG_TAPS         = 8;
   localparam int SAMPLE_BITS      = 10;
   localparam int LED_PERIOD       = 10;
   localparam int BAND_COUNT       = 10;
   localparam int TICKS_PER_MINUTE = 60;

   localparam int PTR_BITS   = $clog2(AVG_TAPS);
   localparam int SUM_BITS   = SAMPLE_BITS + PTR_BITS;
   localparam int HOLD_BITS  = 14;
   localparam int PHASE_BITS = $clog2(LED_PERIOD + 1);
   localparam int LEDCNT_BITS = $clog2(BAND_COUNT + 1);
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 10;

   localparam logic [9:0] BASE_RESET    = 10'd556;
   localparam logic [3:0] OFFSET_RESET  = 4'd0;
   localparam logic [5:0] HYST_RESET    = 6'd3;
   localparam logic [5:0] HYST_MAX      = 6'd55;
   localparam logic [7:0] STARTUP_RESET = 8'd80;
   localparam logic [7:0] HOLD_RESET    = 8'd3;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_BASE_LEVEL      = 3'd0,
      REG_ON_OFFSET       = 3'd1,
      REG_HYSTERESIS      = 3'd2,
      REG_STARTUP_MINUTES = 3'd3,
      REG_HOLD_MINUTES    = 3'd4
   } csr_index_type;

   typedef logic [SAMPLE_BITS-1:0] band_table_type [BAND_COUNT];

   localparam band_table_type BAND_FLOOR = '{
      10'd577, 10'd587, 10'd598, 10'd608, 10'd618,
      10'd628, 10'd638, 10'd647, 10'd657, 10'd666
   };

   function automatic logic [HOLD_BITS-1:0] minutes_to_ticks(input logic [7:0] minutes);
      logic [HOLD_BITS+1:0] prod;
      prod = {{(HOLD_BITS-6){1'b0}}, minutes} * (HOLD_BITS+2)'(TICKS_PER_MINUTE);
      return prod[HOLD_BITS-1:0];
   endfunction

   function automatic logic [LEDCNT_BITS-1:0] band_count(input logic [SAMPLE_BITS-1:0] avg);
      logic [LEDCNT_BITS-1:0] n;
      n = '0;
      for (int k = 0; k < BAND_COUNT; k++) begin
         if (avg >= BAND_FLOOR[k]) begin
            n = n + 1'b1;
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

[src/ahpt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ahpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[src/averaged_hysteresis_pump_thermostat.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  ports                           word
// req      in         req_tvalid/tready/tdata         sample
// rsp      out        rsp_tvalid/tready/tdata         pump_on, led_on, average, holding
// csr      in         csr_wen/csr_addr/csr_wdata      register write, no read-back
//
// one word accepted per cycle unless a stalled result backs up to the input
// the ring read, the running sum and the control update are each one stage
// reset is synchronous; the ring reads as zero through per-entry valid bits
// a stalled result holds all stages that are full; empty stages still fill

module averaged_hysteresis_pump_thermostat
   import ahpt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [15:0]              req_tdata,   // [9:0] sample
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [15:0]              rsp_tdata,   // [0] pump_on, [1] led_on,
                                                      // [11:2] average, [12] holding
   input  wire logic                     csr_wen,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // configuration
   logic [9:0] base_ff;
   logic [3:0] offset_ff;
   logic [5:0] hyst_ff;
   logic [7:0] holdmin_ff;

   // pipeline
   logic                   ticked_ff;
   logic [PTR_BITS-1:0]    ptr_ff;
   logic [AVG_TAPS-1:0]    ring_valid_ff;
   logic                   s1_valid_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [PTR_BITS-1:0]    s1_addr_ff;
   logic [SUM_BITS-1:0]    sum_ff;
   logic [SUM_BITS-1:0]    sum_in;
   logic                   s2_valid_ff;
   logic [SAMPLE_BITS-1:0] s2_avg_ff;

   // control state
   logic [HOLD_BITS-1:0]   hold_ff,      hold_in;
   logic                   pump_ff,      pump_in;
   logic                   led_ff,       led_in;
   logic [PHASE_BITS-1:0]  phase_ff,     phase_in;
   logic [LEDCNT_BITS-1:0] ledcnt_ff,    ledcnt_in;
   logic                   startup_flag_ff, startup_flag_in;

   logic                   out_valid_ff;
   logic [SAMPLE_BITS-1:0] out_avg_ff;

   logic                   accept;
   logic                   out_free, s2_adv, s2_free, s1_adv, s1_free;
   logic [SAMPLE_BITS-1:0] ram_rdata, old_sample;
   logic [10:0]            on_level;
   logic signed [11:0]     off_level;
   logic                   off_hit, on_hit;
   logic [LEDCNT_BITS-1:0] band_n;
   logic [PHASE_BITS-1:0]  phase_step;
   logic [LEDCNT_BITS-1:0] ledcnt_load;
   logic [HOLD_BITS-1:0]   hold_dec;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s2_adv     = s2_valid_ff && out_free;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_adv     = s1_valid_ff && s2_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_tready = s1_free;
   assign accept     = req_tvalid && req_tready;

   ahpt_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (AVG_TAPS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_sample_ff),
      .rd_en   (accept),
      .rd_addr (ptr_ff),
      .rd_data (ram_rdata)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= BASE_RESET;
         offset_ff  <= OFFSET_RESET;
         hyst_ff    <= HYST_RESET;
         holdmin_ff <= HOLD_RESET;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_addr))
            REG_BASE_LEVEL:      base_ff    <= csr_wdata[9:0];
            REG_ON_OFFSET:       offset_ff  <= csr_wdata[3:0];
            REG_HYSTERESIS:      hyst_ff    <= (csr_wdata[5:0] > HYST_MAX) ? HYST_MAX
                                                                            : csr_wdata[5:0];
            REG_HOLD_MINUTES:    holdmin_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // stage 1: ring entry read, running sum, write-back
   assign old_sample = ring_valid_ff[s1_addr_ff] ? ram_rdata : '0;
   assign sum_in     = sum_ff - SUM_BITS'(old_sample) + SUM_BITS'(s1_sample_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ticked_ff     <= 1'b0;
         ptr_ff        <= '0;
         ring_valid_ff <= '0;
         s1_valid_ff   <= 1'b0;
         sum_ff        <= '0;
         s2_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            ticked_ff <= 1'b1;
            ptr_ff    <= (ptr_ff == PTR_BITS'(AVG_TAPS - 1)) ? '0 : ptr_ff + 1'b1;
         end
         if (s1_free) begin
            s1_valid_ff <= accept;
         end
         if (s1_adv) begin
            ring_valid_ff[s1_addr_ff] <= 1'b1;
            sum_ff                    <= sum_in;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_adv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_tdata[SAMPLE_BITS-1:0];
         s1_addr_ff   <= ptr_ff;
      end
      if (s1_adv) begin
         s2_avg_ff <= sum_in[SUM_BITS-1:PTR_BITS];
      end
   end

   // stage 2: hold, pump and led control
   assign on_level  = 11'(base_ff) + 11'(offset_ff) * 11'd10;
   assign off_level = 12'(signed'({2'b00, base_ff}))
                    + (12'(signed'({1'b0, offset_ff})) - 12'(signed'({1'b0, hyst_ff})))
                      * 12'sd10;
   assign off_hit   = signed'({2'b00, s2_avg_ff}) <= off_level;
   assign on_hit    = 11'(s2_avg_ff) >= on_level;
   assign band_n    = band_count(s2_avg_ff);
   assign hold_dec  = hold_ff - 1'b1;

   always_comb begin
      hold_in         = hold_ff;
      pump_in         = pump_ff;
      led_in          = led_ff;
      phase_in        = phase_ff;
      ledcnt_in       = ledcnt_ff;
      startup_flag_in = startup_flag_ff;
      phase_step      = phase_ff + 1'b1;
      ledcnt_load     = ledcnt_ff;
      if (s2_adv) begin
         if (hold_ff != '0) begin
            hold_in = hold_dec;
            if (hold_dec == '0) begin
               if (!startup_flag_ff && off_hit) begin
                  pump_in = 1'b0;
               end
               startup_flag_in = 1'b0;
            end
         end else begin
            startup_flag_in = 1'b0;
            if (phase_step > PHASE_BITS'(LED_PERIOD - 1)) begin
               phase_in = '0;
               if (band_n != '0) begin
                  ledcnt_load = band_n;
               end
            end else begin
               phase_in = phase_step;
            end
            if (ledcnt_load != '0) begin
               led_in    = 1'b1;
               ledcnt_in = ledcnt_load - 1'b1;
            end else begin
               led_in    = 1'b0;
               ledcnt_in = ledcnt_load;
            end
            if (on_hit) begin
               pump_in = 1'b1;
               hold_in = minutes_to_ticks(holdmin_ff);
            end
            if (hold_in == '0 && off_hit) begin
               pump_in = 1'b0;
            end
         end
      end else if (csr_wen && csr_index_type'(csr_addr) == REG_STARTUP_MINUTES
                   && !ticked_ff) begin
         hold_in = minutes_to_ticks(csr_wdata[7:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff         <= minutes_to_ticks(STARTUP_RESET);
         pump_ff         <= 1'b1;
         led_ff          <= 1'b0;
         phase_ff        <= '0;
         ledcnt_ff       <= '0;
         startup_flag_ff <= 1'b1;
         out_valid_ff    <= 1'b0;
      end else begin
         hold_ff         <= hold_in;
         pump_ff         <= pump_in;
         led_ff          <= led_in;
         phase_ff        <= phase_in;
         ledcnt_ff       <= ledcnt_in;
         startup_flag_ff <= startup_flag_in;
         if (out_free) begin
            out_valid_ff <= s2_adv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         out_avg_ff <= s2_avg_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, (hold_ff != '0), out_avg_ff, led_ff, pump_ff};

   // checks
   a_pump_on_while_holding: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12] |-> rsp_tdata[0])
      else $error("pump off during a hold");

   a_hold_range: assert property (@(posedge clock) disable iff (reset)
      hold_ff <= minutes_to_ticks(8'd255))
      else $error("hold counter out of range");

   a_led_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff < PHASE_BITS'(LED_PERIOD) && ledcnt_ff < LEDCNT_BITS'(BAND_COUNT))
      else $error("led counters out of range");

   a_s1_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_addr_ff)
                                 && $stable(s1_sample_ff))
      else $error("ring stage lost its word during a stall");

endmodule

`default_nettype wire
